### rtl/core/idl_pkg.sv
`timescale 1ns / 1ps

package idl_pkg;

   localparam int CAPACITY      = 16;
   localparam int ELEMENT_WIDTH = 32;

   localparam int COMMAND_W = 2;
   localparam int POSITION_W = 5;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int DATA_W    = 32;
   localparam int ENTRIES_W = 5;

   localparam int COUNT_W   = $clog2(CAPACITY + 1);
   localparam int INDEX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COMPARE_W = (COUNT_W > POSITION_W) ? COUNT_W + 1 : POSITION_W + 1;

   localparam logic [COMMAND_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_type;

endpackage

### rtl/core/idl_if.sv
`timescale 1ns / 1ps

interface idl_req_if;
   logic                                valid;
   logic                                ready;
   logic [idl_pkg::COMMAND_W-1:0]       command;
   logic [idl_pkg::POSITION_W-1:0]      position;
   logic signed [idl_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output command, output position, output value, input ready);
   modport sink (input valid, input command, input position, input value, output ready);
endinterface

interface idl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [idl_pkg::STATUS_W-1:0]        status;
   logic signed [idl_pkg::DATA_W-1:0]   data;
   logic [idl_pkg::ENTRIES_W-1:0]       entries;

   modport source (output valid, output status, output data, output entries, input ready);
   modport sink (input valid, input status, input data, input entries, output ready);
endinterface

### rtl/core/idl_ctrl.sv
`timescale 1ns / 1ps

module idl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output idl_pkg::ctrl_type    ctrl
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = (state_ff == S_RESP);
   assign ctrl.capture = (state_ff == S_IDLE) && req_valid;
   assign ctrl.execute = (state_ff == S_EXEC);

endmodule

### rtl/core/idl_datapath.sv
`timescale 1ns / 1ps

module idl_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  idl_pkg::ctrl_type                   ctrl,
   input  logic [idl_pkg::COMMAND_W-1:0]       command,
   input  logic [idl_pkg::POSITION_W-1:0]      position,
   input  logic signed [idl_pkg::VALUE_W-1:0]  value,
   output logic [idl_pkg::STATUS_W-1:0]        status,
   output logic signed [idl_pkg::DATA_W-1:0]   data,
   output logic [idl_pkg::ENTRIES_W-1:0]       entries
);

   localparam int CAP = idl_pkg::CAPACITY;
   localparam int EW  = idl_pkg::ELEMENT_WIDTH;
   localparam int CW  = idl_pkg::COMPARE_W;

   logic [EW-1:0]                     elem_ff [CAP];
   logic [EW-1:0]                     elem_in [CAP];
   logic [EW-1:0]                     below   [CAP];
   logic [EW-1:0]                     above   [CAP];
   logic [idl_pkg::COUNT_W-1:0]       count_ff;
   logic [idl_pkg::COUNT_W-1:0]       count_in;
   logic [idl_pkg::COMMAND_W-1:0]     cmd_ff;
   logic [idl_pkg::POSITION_W-1:0]    pos_ff;
   logic [EW-1:0]                     val_ff;
   logic [idl_pkg::STATUS_W-1:0]      status_ff;
   logic [idl_pkg::STATUS_W-1:0]      status_in;
   logic [idl_pkg::DATA_W-1:0]        data_ff;
   logic [idl_pkg::DATA_W-1:0]        data_in;
   logic [CW-1:0]                     pos_ext;
   logic [CW-1:0]                     count_ext;
   logic [EW-1:0]                     selected;

   for (genvar g = 0; g < CAP; g++) begin : g_neighbors
      if (g > 0) begin : g_below
         assign below[g] = elem_ff[g-1];
      end else begin : g_first
         assign below[g] = elem_ff[g];
      end
      if (g < CAP - 1) begin : g_above
         assign above[g] = elem_ff[g+1];
      end else begin : g_last
         assign above[g] = elem_ff[g];
      end
   end

   assign pos_ext   = CW'(pos_ff);
   assign count_ext = CW'(count_ff);
   assign selected  = elem_ff[pos_ff[idl_pkg::INDEX_W-1:0]];

   always_comb begin
      elem_in   = elem_ff;
      count_in  = count_ff;
      status_in = status_ff;
      data_in   = data_ff;
      if (ctrl.execute) begin
         status_in = idl_pkg::ST_OK;
         data_in   = '0;
         case (cmd_ff)
            idl_pkg::CMD_INSERT: begin
               if (count_ext >= CW'(CAP)) begin
                  status_in = idl_pkg::ST_FULL;
               end else if (pos_ext > count_ext) begin
                  status_in = idl_pkg::ST_RANGE;
               end else begin
                  for (int i = 0; i < CAP; i++) begin
                     if (CW'(i) == pos_ext) begin
                        elem_in[i] = val_ff;
                     end else if (CW'(i) > pos_ext && CW'(i) <= count_ext) begin
                        elem_in[i] = below[i];
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            idl_pkg::CMD_REMOVE, idl_pkg::CMD_READ: begin
               if (pos_ext >= count_ext) begin
                  status_in = idl_pkg::ST_RANGE;
               end else begin
                  data_in = idl_pkg::DATA_W'(selected);
                  if (cmd_ff == idl_pkg::CMD_REMOVE) begin
                     for (int i = 0; i < CAP; i++) begin
                        if (CW'(i) >= pos_ext && CW'(i) + CW'(1) < count_ext) begin
                           elem_in[i] = above[i];
                        end
                     end
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            default: begin
               status_in = idl_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff   <= elem_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      if (ctrl.capture) begin
         cmd_ff <= command;
         pos_ff <= position;
         val_ff <= EW'(value);
      end
   end

   assign status  = status_ff;
   assign data    = data_ff;
   assign entries = idl_pkg::ENTRIES_W'(count_ff);

endmodule

### rtl/core/indexed_insert_remove_list_core.sv
`timescale 1ns / 1ps
// The controller steps through an accept, execute and respond sequence: the
// request is captured on accept, the result is computed and registered in the
// execute state and offered in the respond state. A new request is accepted only
// after the last response has transferred; a stalled response holds the next one.
// Reset clears the entry count and the controller; the element store is not
// cleared, since only entries below the count are ever read.

module indexed_insert_remove_list_core (
   input  logic      clock,
   input  logic      reset,
   idl_req_if.sink   req_ch,
   idl_rsp_if.source rsp_ch
);

   idl_pkg::ctrl_type ctrl;

   idl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   idl_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .command  (req_ch.command),
      .position (req_ch.position),
      .value    (req_ch.value),
      .status   (rsp_ch.status),
      .data     (rsp_ch.data),
      .entries  (rsp_ch.entries)
   );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [idl_pkg::COMMAND_W-1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [idl_pkg::STATUS_W-1:0]  status;
      logic [idl_pkg::DATA_W-1:0]    data;
      logic [idl_pkg::ENTRIES_W-1:0] entries;
   } list_result_type;

   logic clock;
   logic reset;

   idl_req_if req_if ();
   idl_rsp_if rsp_if ();

   indexed_insert_remove_list_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   logic [idl_pkg::ELEMENT_WIDTH-1:0] list_mem [idl_pkg::CAPACITY];
   int                                list_count;
   list_result_type                   pending_results [$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int error_count;
   int quiet_cycles;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic list_result_type apply_list_operation(
         input logic [idl_pkg::COMMAND_W-1:0]  cmd,
         input logic [idl_pkg::POSITION_W-1:0] pos,
         input logic [idl_pkg::VALUE_W-1:0]    val);
      list_result_type res;
      int              p;
      res = '0;
      res.status = idl_pkg::ST_OK;
      p = int'(pos);
      case (cmd)
         idl_pkg::CMD_INSERT: begin
            if (list_count >= idl_pkg::CAPACITY) begin
               res.status = idl_pkg::ST_FULL;
            end else if (p > list_count) begin
               res.status = idl_pkg::ST_RANGE;
            end else begin
               for (int i = list_count; i > p; i--) list_mem[i] = list_mem[i-1];
               list_mem[p] = val[idl_pkg::ELEMENT_WIDTH-1:0];
               list_count++;
            end
         end
         idl_pkg::CMD_REMOVE, idl_pkg::CMD_READ: begin
            if (p >= list_count || p >= idl_pkg::CAPACITY) begin
               res.status = idl_pkg::ST_RANGE;
            end else begin
               res.data = idl_pkg::DATA_W'(list_mem[p]);
               if (cmd == idl_pkg::CMD_REMOVE) begin
                  for (int i = p; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
                  list_count--;
               end
            end
         end
         default: begin
         end
      endcase
      res.entries = idl_pkg::ENTRIES_W'(list_count);
      return res;
   endfunction

   function automatic logic [idl_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(7))
         0: return {1'b1, {(idl_pkg::VALUE_W-1){1'b0}}};
         1: return {1'b0, {(idl_pkg::VALUE_W-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_list_op(input logic [idl_pkg::COMMAND_W-1:0] cmd,
                               input logic [idl_pkg::POSITION_W-1:0] pos,
                               input logic [idl_pkg::VALUE_W-1:0] val);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid    <= 1'b1;
      req_if.command  <= cmd;
      req_if.position <= pos;
      req_if.value    <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_results.push_back(apply_list_operation(cmd, pos, val));
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic run_list_traffic(input int n_ops);
      logic [idl_pkg::COMMAND_W-1:0]  cmd;
      logic [idl_pkg::POSITION_W-1:0] pos;
      int                             fill_goal;
      int                             pick;
      fill_goal = $urandom_range(idl_pkg::CAPACITY);
      for (int n = 0; n < n_ops; n++) begin
         if (n % 48 == 47) begin
            case ($urandom_range(2))
               0: fill_goal = 0;
               1: fill_goal = idl_pkg::CAPACITY;
               default: fill_goal = $urandom_range(idl_pkg::CAPACITY);
            endcase
         end
         pick = $urandom_range(99);
         if (pick < 4) begin
            cmd = idl_pkg::COMMAND_W'($urandom_range(CMD_UNUSED));
            pos = idl_pkg::POSITION_W'($urandom_range(2 ** idl_pkg::POSITION_W - 1));
         end else if (pick < 12) begin
            cmd = idl_pkg::COMMAND_W'($urandom_range(idl_pkg::CMD_READ));
            if (cmd != idl_pkg::CMD_INSERT) begin
               pos = idl_pkg::POSITION_W'($urandom_range(idl_pkg::CAPACITY, list_count));
            end else if (list_count < idl_pkg::CAPACITY) begin
               pos = idl_pkg::POSITION_W'($urandom_range(idl_pkg::CAPACITY,
                                                         list_count + 1));
            end else begin
               pos = idl_pkg::POSITION_W'($urandom_range(idl_pkg::CAPACITY));
            end
         end else if ($urandom_range(99) < ((list_count < fill_goal) ? 75 : 25)) begin
            cmd = idl_pkg::CMD_INSERT;
            pos = idl_pkg::POSITION_W'($urandom_range(list_count));
         end else begin
            cmd = $urandom_range(1) ? idl_pkg::CMD_REMOVE : idl_pkg::CMD_READ;
            pos = (list_count == 0) ? '0
                                    : idl_pkg::POSITION_W'($urandom_range(list_count - 1));
         end
         send_list_op(cmd, pos, random_value());
      end
   endtask

   task automatic test_empty_list();
      set_idling(0, 0);
      send_list_op(idl_pkg::CMD_READ, 0, '0);
      send_list_op(idl_pkg::CMD_REMOVE, 0, '0);
      send_list_op(idl_pkg::CMD_INSERT, 1, 32'h1234_5678);
      wait_for_results();
   endtask

   task automatic test_insert_positions();
      send_list_op(idl_pkg::CMD_INSERT, 0, 32'h8000_0000);
      send_list_op(idl_pkg::CMD_INSERT, 1, 32'h7FFF_FFFF);
      send_list_op(idl_pkg::CMD_INSERT, 0, 32'hFFFF_FFFF);
      send_list_op(idl_pkg::CMD_INSERT, 2, 32'h0000_0000);
      send_list_op(idl_pkg::CMD_INSERT, 31, 32'hA5A5_A5A5);
      send_list_op(idl_pkg::CMD_READ, 0, '0);
      send_list_op(idl_pkg::CMD_READ, 3, '0);
      send_list_op(idl_pkg::CMD_READ, 4, '0);
      wait_for_results();
   endtask

   task automatic test_unused_command();
      send_list_op(CMD_UNUSED, 31, 32'h5555_5555);
      wait_for_results();
   endtask

   task automatic test_full_list();
      while (list_count < idl_pkg::CAPACITY) begin
         send_list_op(idl_pkg::CMD_INSERT, idl_pkg::POSITION_W'(list_count), random_value());
      end
      send_list_op(idl_pkg::CMD_INSERT, 0, 32'h0F0F_0F0F);
      send_list_op(idl_pkg::CMD_INSERT, 31, 32'hF0F0_F0F0);
      send_list_op(idl_pkg::CMD_READ, 16, '0);
      wait_for_results();
   endtask

   task automatic test_remove_positions();
      send_list_op(idl_pkg::CMD_REMOVE, 0, '0);
      send_list_op(idl_pkg::CMD_REMOVE, 14, '0);
      send_list_op(idl_pkg::CMD_REMOVE, 6, '0);
      wait_for_results();
   endtask

   task automatic test_random_no_idle();
      set_idling(0, 0);
      run_list_traffic(450);
      wait_for_results();
   endtask

   task automatic test_random_sender_idle();
      set_idling(72, 0);
      run_list_traffic(350);
      wait_for_results();
   endtask

   task automatic test_random_receiver_stall();
      set_idling(0, 72);
      run_list_traffic(350);
      wait_for_results();
   endtask

   task automatic test_random_both_idle();
      set_idling(34, 34);
      run_list_traffic(350);
      wait_for_results();
   endtask

   task automatic test_receiver_hold_off();
      set_idling(0, 0);
      hold_left = 150;
      run_list_traffic(100);
      wait_for_results();
   endtask

   task automatic test_sender_pause();
      set_idling(0, 34);
      run_list_traffic(40);
      wait_for_results();
      run_list_traffic(40);
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, status %0d data %0d entries %0d",
                     $time, rsp_if.status, rsp_if.data, rsp_if.entries);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.data !== want.data) begin
               $display("%0t: data mismatch, expected %0d, actual %0d",
                        $time, $signed(want.data), rsp_if.data);
               error_count++;
            end
            if (rsp_if.entries !== want.entries) begin
               $display("%0t: entries mismatch, expected %0d, actual %0d",
                        $time, want.entries, rsp_if.entries);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.command  = idl_pkg::CMD_INSERT;
      req_if.position = '0;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_left       = 0;
      error_count     = 0;
      quiet_cycles    = 0;
      list_count      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_insert_positions();
      test_unused_command();
      test_full_list();
      test_remove_positions();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      test_receiver_hold_off();
      test_sender_pause();

      wait_for_results();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/idl_pkg.sv
rtl/core/idl_if.sv
rtl/core/idl_ctrl.sv
rtl/core/idl_datapath.sv
rtl/core/indexed_insert_remove_list_core.sv
tb/tb.sv
